/* design/rvmd_pkg.sv */
// Shared types and constants for the RV32M multiply/divide unit.
`default_nettype none

package rvmd_pkg;

    // Data path width, also the number of cells in the chain, and destination index width.
    localparam int unsigned XLEN = 32;
    localparam int unsigned REG_W = 5;

    // Operation codes, taken straight from funct3.
    typedef enum logic [2:0] {
        OP_MUL    = 3'd0,
        OP_MULH   = 3'd1,
        OP_MULHSU = 3'd2,
        OP_MULHU  = 3'd3,
        OP_DIV    = 3'd4,
        OP_DIVU   = 3'd5,
        OP_REM    = 3'd6,
        OP_REMU   = 3'd7
    } t_op;

    // One pipeline slot as it travels down the chain of cells.
    // For multiplies acc is the running high word and x the multiplier,
    // which is shifted out to the right while the low product shifts in.
    // For divides acc is the partial remainder and x the dividend, which is
    // shifted out to the left while the quotient bits shift in.
    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [REG_W-1:0] dest;
        logic             neg;
        logic             div0;
        logic [XLEN-1:0]  acc;
        logic [XLEN-1:0]  x;
        logic [XLEN-1:0]  y;
    } t_stage;

endpackage

`default_nettype wire

/* design/rv32m_multiply_divide_unit.sv */
// RV32M multiply/divide unit: top level with the chain of 32 bit-step cells.
//
// The slave channel takes one operation per transaction: funct3 code, both
// source operands and the destination register index. The master channel
// returns one transaction per operation, in order: the 32-bit result and the
// destination index copied from the input.
// Multiplies run as shift-add and divides as restoring division over a chain
// of 32 identical cells, one operand bit per cell; each cell hands its slot to
// the next one every cycle while the chain is enabled. The result is registered
// in turn by the input stage, each of the 32 cells and the output register. A
// new operation is taken every cycle while the skid entry is free; the 33-bit
// adder and 34-bit subtractor in each cell set the clock period.
// Reset clears all valid flags, so the pipeline and output come up empty.
// A result waiting on a stalled receiver goes into a one-entry skid register,
// and the chain keeps moving until that entry fills; o_s_tready then drops
// until the receiver takes a result again. Nothing is dropped or repeated.
`default_nettype none

module rv32m_multiply_divide_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [2:0] op, [34:3] operand_a, [66:35] operand_b, [71:67] dest_reg
    input  wire logic [71:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [31:0] result_value, [36:32] result_reg, [39:37] zero
    output logic [39:0]      o_m_tdata
);

    rvmd_pkg::t_stage               chain [rvmd_pkg::XLEN+1];
    logic                           en;
    logic [rvmd_pkg::XLEN-1:0]      res_value;
    logic [rvmd_pkg::REG_W-1:0]     res_reg;

    assign o_s_tready = en;

    // Input stage: operand magnitudes and sign flags.
    rvmd_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_op    (rvmd_pkg::t_op'(i_s_tdata[2:0])),
        .i_a     (i_s_tdata[34:3]),
        .i_b     (i_s_tdata[66:35]),
        .i_dest  (i_s_tdata[71:67]),
        .o_stage (chain[0])
    );

    // One cell per operand bit.
    for (genvar g = 0; g < rvmd_pkg::XLEN; g++) begin : g_cell
        rvmd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    // Result selection and output buffering.
    rvmd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (chain[rvmd_pkg::XLEN]),
        .i_en    (en),
        .o_en    (en),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_value (res_value),
        .o_reg   (res_reg)
    );

    assign o_m_tdata = {3'b000, res_reg, res_value};

endmodule

`default_nettype wire

/* design/rvmd_prep.sv */
// Input stage: takes operand magnitudes and sign flags into the first slot.
`default_nettype none

module rvmd_prep (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire logic                             i_valid,
    input  wire rvmd_pkg::t_op                    i_op,
    input  wire logic [rvmd_pkg::XLEN-1:0]        i_a,
    input  wire logic [rvmd_pkg::XLEN-1:0]        i_b,
    input  wire logic [rvmd_pkg::REG_W-1:0]       i_dest,
    output rvmd_pkg::t_stage                      o_stage
);

    logic             a_signed;
    logic             b_signed;
    logic             a_neg;
    logic             b_neg;
    logic             res_neg;
    rvmd_pkg::t_stage r_stage;
    rvmd_pkg::t_stage n_stage;

    // Decide which operands are read as signed for this operation.
    always_comb begin
        unique case (i_op)
            rvmd_pkg::OP_MULH, rvmd_pkg::OP_DIV, rvmd_pkg::OP_REM: begin
                a_signed = 1'b1;
                b_signed = 1'b1;
            end
            rvmd_pkg::OP_MULHSU: begin
                a_signed = 1'b1;
                b_signed = 1'b0;
            end
            default: begin
                a_signed = 1'b0;
                b_signed = 1'b0;
            end
        endcase
    end

    assign a_neg = a_signed & i_a[rvmd_pkg::XLEN-1];
    assign b_neg = b_signed & i_b[rvmd_pkg::XLEN-1];

    // A signed remainder follows the dividend; everything else follows both.
    assign res_neg = (i_op == rvmd_pkg::OP_REM) ? a_neg : (a_neg ^ b_neg);

    // Build the first slot of the chain.
    always_comb begin
        n_stage       = r_stage;
        n_stage.valid = i_valid;
        n_stage.op    = i_op;
        n_stage.dest  = i_dest;
        n_stage.neg   = res_neg;
        n_stage.div0  = (i_b == '0);
        n_stage.acc   = '0;
        n_stage.x     = a_neg ? (~i_a + 1'b1) : i_a;
        n_stage.y     = b_neg ? (~i_b + 1'b1) : i_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

/* design/rvmd_cell.sv */
// One cell of the chain: a shift-add multiply step or a restoring divide step.
`default_nettype none

module rvmd_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire rvmd_pkg::t_stage i_stage,
    output rvmd_pkg::t_stage      o_stage
);

    logic [rvmd_pkg::XLEN:0]   mul_sum;
    logic [rvmd_pkg::XLEN:0]   div_rem;
    logic [rvmd_pkg::XLEN+1:0] div_diff;
    logic                      div_ge;
    rvmd_pkg::t_stage          r_stage;
    rvmd_pkg::t_stage          n_stage;

    // Multiply step: add the multiplicand if the current multiplier bit is set.
    assign mul_sum = {1'b0, i_stage.acc}
                   + (i_stage.x[0] ? {1'b0, i_stage.y} : '0);

    // Divide step: bring down the next dividend bit and try to subtract.
    assign div_rem  = {i_stage.acc, i_stage.x[rvmd_pkg::XLEN-1]};
    assign div_diff = {1'b0, div_rem} - {2'b00, i_stage.y};
    assign div_ge   = ~div_diff[rvmd_pkg::XLEN+1];

    always_comb begin
        n_stage = i_stage;
        if (i_stage.op[2]) begin
            n_stage.acc = div_ge ? div_diff[rvmd_pkg::XLEN-1:0]
                                 : div_rem[rvmd_pkg::XLEN-1:0];
            n_stage.x   = {i_stage.x[rvmd_pkg::XLEN-2:0], div_ge};
        end else begin
            n_stage.acc = mul_sum[rvmd_pkg::XLEN:1];
            n_stage.x   = {mul_sum[0], i_stage.x[rvmd_pkg::XLEN-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

/* design/rvmd_out.sv */
// Output stage: result selection, sign fix-up and a two-entry skid buffer.
`default_nettype none

module rvmd_out (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire rvmd_pkg::t_stage             i_stage,
    input  wire logic                         i_en,
    output logic                              o_en,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [rvmd_pkg::XLEN-1:0]         o_value,
    output logic [rvmd_pkg::REG_W-1:0]        o_reg
);

    logic [rvmd_pkg::XLEN-1:0]  hi_neg;
    logic [rvmd_pkg::XLEN-1:0]  res;
    logic                       in_valid;
    logic                       take;
    logic                       r_out_valid;
    logic [rvmd_pkg::XLEN-1:0]  r_out_value;
    logic [rvmd_pkg::REG_W-1:0] r_out_reg;
    logic                       r_skid_valid;
    logic [rvmd_pkg::XLEN-1:0]  r_skid_value;
    logic [rvmd_pkg::REG_W-1:0] r_skid_reg;

    // High word of the negated 64-bit product: invert, carry in when low is zero.
    assign hi_neg = ~i_stage.acc + {{(rvmd_pkg::XLEN-1){1'b0}}, (i_stage.x == '0)};

    // Pick the word the operation asks for and apply its sign.
    always_comb begin
        unique case (i_stage.op)
            rvmd_pkg::OP_MUL: begin
                res = i_stage.x;
            end
            rvmd_pkg::OP_MULH, rvmd_pkg::OP_MULHSU, rvmd_pkg::OP_MULHU: begin
                res = i_stage.neg ? hi_neg : i_stage.acc;
            end
            rvmd_pkg::OP_DIV, rvmd_pkg::OP_DIVU: begin
                if (i_stage.div0) begin
                    res = '1;
                end else begin
                    res = i_stage.neg ? (~i_stage.x + 1'b1) : i_stage.x;
                end
            end
            default: begin
                res = i_stage.neg ? (~i_stage.acc + 1'b1) : i_stage.acc;
            end
        endcase
    end

    // The chain moves only while the skid entry is free.
    assign o_en     = ~r_skid_valid;
    assign in_valid = i_en & i_stage.valid;
    assign take     = r_out_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_value  <= r_skid_value;
                r_out_reg    <= r_skid_reg;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_valid;
                r_out_value <= res;
                r_out_reg   <= i_stage.dest;
            end
        end else if (in_valid) begin
            r_skid_valid <= 1'b1;
            r_skid_value <= res;
            r_skid_reg   <= i_stage.dest;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_reg   = r_out_reg;

endmodule

`default_nettype wire

/* verif/tb_rv32m_multiply_divide_unit.sv */
// Self-checking testbench for the RV32M multiply/divide unit.
`timescale 1ns / 100ps

module tb_rv32m_multiply_divide_unit;

    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 2;
    localparam int RANDOM_PER_PHASE = 420;
    localparam int RX_HOLD_CYCLES = 150;
    localparam int PIPE_LATENCY = 33;
    localparam int DRAIN_LIMIT = 5000;
    localparam int TIMEOUT_CYCLES = 200000;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;
    localparam logic [31:0] MOST_POSITIVE = 32'h7FFF_FFFF;

    // One directed row; when known is set, the result is typed in here.
    typedef struct packed {
        rvmd_pkg::t_op op;
        logic [31:0]   a;
        logic [31:0]   b;
        logic [4:0]    rd;
        logic          known;
        logic [31:0]   want;
    } t_vector;

    // One writeback that the unit still owes.
    typedef struct {
        rvmd_pkg::t_op op;
        logic [31:0]   value;
        logic [4:0]    rd;
    } t_writeback;

    localparam int NUM_DIRECTED = 25;
    localparam t_vector DIRECTED[NUM_DIRECTED] = '{
        '{rvmd_pkg::OP_MUL,    32'h0000_0000, 32'h0000_0000, 5'd0,  1'b1, 32'h0000_0000},
        '{rvmd_pkg::OP_MUL,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 1'b1, 32'h0000_0001},
        '{rvmd_pkg::OP_MUL,    32'h7FFF_FFFF, 32'h8000_0000, 5'd5,  1'b0, 32'h0000_0000},
        '{rvmd_pkg::OP_MULH,   32'h8000_0000, 32'h8000_0000, 5'd1,  1'b1, 32'h4000_0000},
        '{rvmd_pkg::OP_MULH,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd2,  1'b1, 32'h0000_0000},
        '{rvmd_pkg::OP_MULH,   32'h7FFF_FFFF, 32'h8000_0000, 5'd3,  1'b0, 32'h0000_0000},
        '{rvmd_pkg::OP_MULHSU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd4,  1'b1, 32'hFFFF_FFFF},
        '{rvmd_pkg::OP_MULHSU, 32'h8000_0000, 32'hFFFF_FFFF, 5'd6,  1'b1, 32'h8000_0000},
        '{rvmd_pkg::OP_MULHSU, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd7,  1'b0, 32'h0000_0000},
        '{rvmd_pkg::OP_MULHU,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd8,  1'b1, 32'hFFFF_FFFE},
        '{rvmd_pkg::OP_MULHU,  32'h8000_0000, 32'h0000_0002, 5'd9,  1'b0, 32'h0000_0000},
        '{rvmd_pkg::OP_DIV,    32'h1234_5678, 32'h0000_0000, 5'd10, 1'b1, 32'hFFFF_FFFF},
        '{rvmd_pkg::OP_DIVU,   32'hFFFF_FFFF, 32'h0000_0000, 5'd11, 1'b1, 32'hFFFF_FFFF},
        '{rvmd_pkg::OP_REM,    32'h8000_0000, 32'h0000_0000, 5'd12, 1'b1, 32'h8000_0000},
        '{rvmd_pkg::OP_REMU,   32'hDEAD_BEEF, 32'h0000_0000, 5'd13, 1'b1, 32'hDEAD_BEEF},
        '{rvmd_pkg::OP_DIV,    32'h8000_0000, 32'hFFFF_FFFF, 5'd14, 1'b1, 32'h8000_0000},
        '{rvmd_pkg::OP_REM,    32'h8000_0000, 32'hFFFF_FFFF, 5'd15, 1'b1, 32'h0000_0000},
        '{rvmd_pkg::OP_DIVU,   32'h8000_0000, 32'hFFFF_FFFF, 5'd16, 1'b0, 32'h0000_0000},
        '{rvmd_pkg::OP_DIV,    32'hFFFF_FFF9, 32'h0000_0002, 5'd17, 1'b0, 32'h0000_0000},
        '{rvmd_pkg::OP_REM,    32'hFFFF_FFF9, 32'h0000_0002, 5'd18, 1'b0, 32'h0000_0000},
        '{rvmd_pkg::OP_DIV,    32'h0000_0007, 32'hFFFF_FFFE, 5'd19, 1'b0, 32'h0000_0000},
        '{rvmd_pkg::OP_REM,    32'h0000_0007, 32'hFFFF_FFFE, 5'd20, 1'b0, 32'h0000_0000},
        '{rvmd_pkg::OP_REMU,   32'hFFFF_FFFF, 32'h0000_0010, 5'd21, 1'b0, 32'h0000_0000},
        '{rvmd_pkg::OP_DIV,    32'h8000_0000, 32'h0000_0001, 5'd22, 1'b1, 32'h8000_0000},
        '{rvmd_pkg::OP_DIVU,   32'h0000_0000, 32'hFFFF_FFFF, 5'd23, 1'b1, 32'h0000_0000}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    // [2:0] op, [34:3] operand_a, [66:35] operand_b, [71:67] dest_reg
    logic [71:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // [31:0] result_value, [36:32] result_reg, [39:37] zero
    logic [39:0] o_m_tdata;

    t_writeback pending_writebacks[$];

    int error_count = 0;
    int results_checked = 0;
    int results_per_op[8];
    int input_stall_cycles = 0;
    int div_by_zero_count = 0;
    int overflow_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_left = 0;
    bit rx_hold_req = 1'b0;

    rv32m_multiply_divide_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Free-running clock.
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Compute the value that an RV32M operation writes back.
    function automatic logic [31:0] rv32m_execute(rvmd_pkg::t_op op, logic [31:0] a,
                                                  logic [31:0] b);
        logic [63:0] ext_a;
        logic [63:0] ext_b;
        logic [63:0] product;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] quot;
        logic [31:0] rem;
        logic        overflow;

        ext_a = (op == rvmd_pkg::OP_MULHU) ? {32'b0, a} : {{32{a[31]}}, a};
        ext_b = (op == rvmd_pkg::OP_MULH) ? {{32{b[31]}}, b} : {32'b0, b};
        product = ext_a * ext_b;
        mag_a = a[31] ? -a : a;
        mag_b = b[31] ? -b : b;
        overflow = (a == MOST_NEGATIVE) && (b == ALL_ONES);

        case (op)
            rvmd_pkg::OP_MUL: begin
                return a * b;
            end
            rvmd_pkg::OP_MULH, rvmd_pkg::OP_MULHSU, rvmd_pkg::OP_MULHU: begin
                return product[63:32];
            end
            rvmd_pkg::OP_DIV: begin
                if (b == 32'd0) return ALL_ONES;
                if (overflow) return MOST_NEGATIVE;
                quot = mag_a / mag_b;
                return (a[31] ^ b[31]) ? -quot : quot;
            end
            rvmd_pkg::OP_DIVU: begin
                return (b == 32'd0) ? ALL_ONES : a / b;
            end
            rvmd_pkg::OP_REM: begin
                if (b == 32'd0) return a;
                if (overflow) return 32'd0;
                rem = mag_a % mag_b;
                return a[31] ? -rem : rem;
            end
            default: begin
                return (b == 32'd0) ? a : a % b;
            end
        endcase
    endfunction

    // Operand mix that favors the corner values of both signednesses.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'd1;
            2: return ALL_ONES;
            3: return MOST_NEGATIVE;
            4: return MOST_POSITIVE;
            5: return 32'($urandom_range(15));
            6: return -32'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    // Print one failure line and count it.
    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Offer one operation, wait for its transaction, and log what it owes.
    task automatic send_op(input rvmd_pkg::t_op op, input logic [31:0] a,
                           input logic [31:0] b, input logic [4:0] rd,
                           input logic [31:0] want);
        t_writeback wb;

        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {rd, b, a, op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);

        wb.op = op;
        wb.value = want;
        wb.rd = rd;
        pending_writebacks.push_back(wb);
        if (op inside {rvmd_pkg::OP_DIV, rvmd_pkg::OP_DIVU, rvmd_pkg::OP_REM,
                       rvmd_pkg::OP_REMU} && b == 32'd0) begin
            div_by_zero_count++;
        end
        if (op inside {rvmd_pkg::OP_DIV, rvmd_pkg::OP_REM} && a == MOST_NEGATIVE
            && b == ALL_ONES) begin
            overflow_count++;
        end
    endtask

    // Random operation, with the signed overflow pair forced now and then.
    task automatic send_random_op();
        rvmd_pkg::t_op op;
        logic [31:0]   a;
        logic [31:0]   b;

        op = rvmd_pkg::t_op'($urandom_range(7));
        a = pick_operand();
        b = pick_operand();
        if ($urandom_range(99) < 3) begin
            a = MOST_NEGATIVE;
            b = ALL_ONES;
        end
        send_op(op, a, b, 5'($urandom_range(31)), rv32m_execute(op, a, b));
    endtask

    // Result consumer: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = RX_HOLD_CYCLES;
            rx_hold_req = 1'b0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each result transaction with the oldest pending writeback.
    always @(posedge i_clk) begin
        t_writeback wb;

        if (i_rst_n) begin
            if (i_s_tvalid && !o_s_tready) input_stall_cycles++;
            if (o_m_tvalid && i_m_tready) begin
                if (pending_writebacks.size() == 0) begin
                    report_error($sformatf("result %h for x%0d with no operation pending",
                                           o_m_tdata[31:0], o_m_tdata[36:32]));
                end else begin
                    wb = pending_writebacks.pop_front();
                    results_checked++;
                    results_per_op[wb.op]++;
                    if (o_m_tdata[31:0] !== wb.value) begin
                        report_error($sformatf("%s result_value %h, expected %h",
                                               wb.op.name(), o_m_tdata[31:0], wb.value));
                    end
                    if (o_m_tdata[36:32] !== wb.rd) begin
                        report_error($sformatf("%s result_reg %0d, expected %0d",
                                               wb.op.name(), o_m_tdata[36:32], wb.rd));
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed table, three random phases, drain.
    initial begin
        int drain_cycles;
        t_vector row;

        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily.
        tx_idle_pct = 17;
        rx_idle_pct = 54;
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row = DIRECTED[i];
            send_op(row.op, row.a, row.b, row.rd,
                    row.known ? row.want : rv32m_execute(row.op, row.a, row.b));
        end
        for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (i == 100) rx_hold_req = 1'b1;
            send_random_op();
        end

        // Roles swapped.
        tx_idle_pct = 54;
        rx_idle_pct = 17;
        for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_op();

        // Full rate on both sides; the hold-off here backs up the whole chain.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_op();
        i_s_tvalid <= 1'b0;

        drain_cycles = 0;
        while (pending_writebacks.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        if (pending_writebacks.size() != 0) begin
            report_error($sformatf("%0d results never arrived", pending_writebacks.size()));
        end

        $display("Checked %0d results: mul %0d, mulh %0d, mulhsu %0d, mulhu %0d,",
                 results_checked, results_per_op[rvmd_pkg::OP_MUL],
                 results_per_op[rvmd_pkg::OP_MULH], results_per_op[rvmd_pkg::OP_MULHSU],
                 results_per_op[rvmd_pkg::OP_MULHU]);
        $display("  div %0d, divu %0d, rem %0d, remu %0d",
                 results_per_op[rvmd_pkg::OP_DIV], results_per_op[rvmd_pkg::OP_DIVU],
                 results_per_op[rvmd_pkg::OP_REM], results_per_op[rvmd_pkg::OP_REMU]);
        $display("Divide by zero %0d times, signed overflow %0d times,",
                 div_by_zero_count, overflow_count);
        $display("  input back-pressured %0d cycles", input_stall_cycles);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("ERROR: run timed out with %0d results pending", pending_writebacks.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
